// ----- hdl/eiudp_pkg.sv -----
// Shared types and constants for the header parser.
package eiudp_pkg;
  localparam int COUNT_BITS  = 16;
  localparam int NAME_LIMIT  = 253;
  localparam int LABEL_LIMIT = 128;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [15:0] DNS_PORT_RESET = 16'd53;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_PARSE  = 2'd1;
  localparam logic [1:0] PH_ACCEPT = 2'd2;
  localparam logic [1:0] PH_REJECT = 2'd3;

  localparam logic [0:0] KIND_CHAR = 1'b0;
  localparam logic [0:0] KIND_SUM  = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_char;
    logic [1:0]  transport;
    logic [1:0]  addr_kind;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] src_port_out;
    logic [15:0] dst_port_out;
    logic [1:0]  dns_state;
    logic [3:0]  dns_rcode;
  } out_item_t;
endpackage

// ----- hdl/eiudp_out_fifo.sv -----
// Small result queue that decouples the parser from the result channel.
module eiudp_out_fifo import eiudp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  out_item_t wr_data,
  output logic [2:0] count,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  out_item_t   mem_r [4];
  logic [1:0]  rd_r, wr_r;
  logic [2:0]  cnt_r;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != 3'd0;
  assign out_data  = mem_r[rd_r];
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_r] <= wr_data;
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wr_r <= wr_r + 2'd1;
      if (pop) rd_r <= rd_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr_en} - {2'd0, pop};
    end
  end
endmodule

// ----- hdl/ethernet_ip_udp_dns_header_parser_top.sv -----
// Top level: byte-serial Ethernet/IP/TCP/UDP header parser with DNS name extraction.
// Flow: an accepted request is registered in the staging register; its first result
//   is written from there into the result queue, from which it can be taken.
// Throughput: one byte per cycle while ready; ready drops while a staged final
//   byte yields a character and the summary, or the queue lacks room for two results.
// Reset (rst_n low, synchronous) clears all frame state, sets dns_port to 53
//   and empties the result queue.
module ethernet_ip_udp_dns_header_parser_top import eiudp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [15:0] cfg_data
);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [15:0] dns_port_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [15:0] eth_r;
  logic [5:0]  ihl_r;
  logic [7:0]  proto_r;
  logic [63:0] src_hi_r, src_lo_r, dst_hi_r, dst_lo_r;
  logic [31:0] ports_r;
  logic [3:0]  rcode_r;
  logic [15:0] qd_r;
  logic [5:0]  left_r;
  logic [7:0]  nlen_r, labels_r;
  logic [1:0]  phase_r;

  // input staging register
  logic     st_v_r;
  in_item_t st_r;

  logic [2:0] fifo_cnt;
  logic       wr_a, wr_b;
  out_item_t  wa, wb, wr_data;
  logic       wr_en;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) dns_port_r <= DNS_PORT_RESET;
    else if (cfg_valid) dns_port_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) st_r <= in_data;
    if (!rst_n) st_v_r <= 1'b0;
    else st_v_r <= in_valid && in_ready;
  end

  // ---- per-byte logic on the staged request ----
  logic [7:0] b;
  logic [COUNT_BITS+1:0] idx, toff, k;
  logic tvalid, dns_match, allowed;
  assign b   = st_r.frame_byte;
  assign idx = {2'd0, cnt_r};
  assign dns_match = ports_r[31:16] == dns_port_r || ports_r[15:0] == dns_port_r;
  assign allowed = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
                   (b >= "0" && b <= "9") || b == "-" || b == "_" || b == ".";

  always_comb begin
    tvalid = 1'b0; toff = '0;
    if (eth_r == ETH_IPV4 && ihl_r >= 6'd20) begin
      tvalid = 1'b1; toff = (COUNT_BITS+2)'(14) + {{(COUNT_BITS-4){1'b0}}, ihl_r};
    end else if (eth_r == ETH_IPV6) begin
      tvalid = 1'b1; toff = (COUNT_BITS+2)'(54);
    end
    k = idx - toff;
  end

  // next-state values
  logic [15:0] eth_n; logic [5:0] ihl_n; logic [7:0] proto_n;
  logic [63:0] shi_n, slo_n, dhi_n, dlo_n; logic [31:0] ports_n;
  logic [3:0] rc_n; logic [15:0] qd_n; logic [5:0] left_n;
  logic [7:0] nlen_n, lab_n; logic [1:0] ph_n; logic [7:0] ch;

  always_comb begin
    eth_n = eth_r; ihl_n = ihl_r; proto_n = proto_r;
    shi_n = src_hi_r; slo_n = src_lo_r; dhi_n = dst_hi_r; dlo_n = dst_lo_r;
    ports_n = ports_r; rc_n = rcode_r; qd_n = qd_r; left_n = left_r;
    nlen_n = nlen_r; lab_n = labels_r; ph_n = phase_r; wr_a = 1'b0; ch = b;
    if (idx == 18'(12)) eth_n = {b, 8'd0};
    else if (idx == 18'(13)) eth_n = {eth_r[15:8], b};
    else if (idx >= 18'(14)) begin
      if (eth_r == ETH_IPV4) begin
        if (idx == 18'(14)) ihl_n = {b[3:0], 2'b00};
        else if (idx == 18'(23)) proto_n = b;
        else if (idx >= 18'(26) && idx <= 18'(29)) slo_n = {src_lo_r[55:0], b};
        else if (idx >= 18'(30) && idx <= 18'(33)) dlo_n = {dst_lo_r[55:0], b};
      end else if (eth_r == ETH_IPV6) begin
        if (idx == 18'(20)) proto_n = b;
        else if (idx >= 18'(22) && idx <= 18'(29)) shi_n = {src_hi_r[55:0], b};
        else if (idx >= 18'(30) && idx <= 18'(37)) slo_n = {src_lo_r[55:0], b};
        else if (idx >= 18'(38) && idx <= 18'(45)) dhi_n = {dst_hi_r[55:0], b};
        else if (idx >= 18'(46) && idx <= 18'(53)) dlo_n = {dst_lo_r[55:0], b};
      end
      if (tvalid && idx >= toff) begin
        if (k <= 18'(3)) ports_n = {ports_r[23:0], b};
        else if (k == 18'(11)) rc_n = b[3:0];
        else if (k == 18'(12) || k == 18'(13)) qd_n = {qd_r[7:0], b};
        else if (k == 18'(20) && phase_r == PH_IDLE && proto_r == PROTO_UDP &&
                 dns_match && qd_r != 16'd0) ph_n = PH_PARSE;
      end
    end
    // name parsing
    if (ph_n == PH_PARSE) begin
      if (left_r == 6'd0) begin
        if (labels_r >= 8'(LABEL_LIMIT)) ph_n = PH_REJECT;
        else if (b == 8'd0) ph_n = PH_ACCEPT;
        else if (b[7:6] != 2'b00) ph_n = PH_REJECT;
        else if (labels_r != 8'd0 && {1'b0, nlen_r} + 9'd1 >= 9'(NAME_LIMIT)) ph_n = PH_REJECT;
        else begin
          if (labels_r != 8'd0) begin
            wr_a = 1'b1; ch = "."; nlen_n = nlen_r + 8'd1;
          end
          left_n = b[5:0];
        end
      end else begin
        if (!allowed || {1'b0, nlen_r} + 9'd1 >= 9'(NAME_LIMIT)) ph_n = PH_REJECT;
        else begin
          wr_a = 1'b1; nlen_n = nlen_r + 8'd1; left_n = left_r - 6'd1;
          if (left_r == 6'd1) lab_n = labels_r + 8'd1;
        end
      end
    end
    wr_a = wr_a && st_v_r;
  end

  // frame summary, built from the state after this byte
  logic [COUNT_BITS+1:0] len, tsum;
  logic [1:0] tr, ak, ds;
  logic [3:0] rc;
  always_comb begin
    len = {2'd0, (cnt_r < CMAX) ? cnt_r + COUNT_BITS'(1) : cnt_r};
    tr = 2'd0; ak = 2'd0; ds = 2'd0; rc = 4'd0; tsum = '0;
    if (len >= 18'(14)) begin
      if (eth_n == ETH_IPV4) begin
        if (len >= 18'(34) && ihl_n >= 6'd20 &&
            len >= 18'(14) + {12'd0, ihl_n}) begin
          ak = 2'd1;
          if (proto_n == PROTO_TCP || proto_n == PROTO_UDP) begin
            tr = (proto_n == PROTO_TCP) ? 2'd1 : 2'd2;
            tsum = 18'(14) + {12'd0, ihl_n};
          end
        end
      end else if (eth_n == ETH_IPV6) begin
        if (len >= 18'(54) && (proto_n == PROTO_TCP || proto_n == PROTO_UDP)) begin
          ak = 2'd2; tr = (proto_n == PROTO_TCP) ? 2'd1 : 2'd2; tsum = 18'(54);
        end
      end
    end
    if (tr == 2'd1 && len < tsum + 18'(20)) tr = 2'd0;
    if (tr == 2'd2 && len < tsum + 18'(8)) tr = 2'd0;
    if (tr == 2'd2 && (ports_n[31:16] == dns_port_r || ports_n[15:0] == dns_port_r) &&
        len >= tsum + 18'(20)) begin
      rc = rc_n;
      if (qd_n == 16'd0) ds = 2'd1;
      else ds = (ph_n == PH_ACCEPT) ? 2'd2 : 2'd3;
    end
    wb = '0;
    wb.kind = KIND_SUM;
    wb.transport = tr; wb.addr_kind = ak;
    if (ak != 2'd0) begin
      wb.src_addr_hi = shi_n; wb.src_addr_lo = slo_n;
      wb.dst_addr_hi = dhi_n; wb.dst_addr_lo = dlo_n;
    end
    if (tr != 2'd0) begin
      wb.src_port_out = ports_n[31:16]; wb.dst_port_out = ports_n[15:0];
    end
    wb.dns_state = ds; wb.dns_rcode = rc;
    wa = '0; wa.kind = KIND_CHAR; wa.name_char = ch;
  end

  assign wr_b = st_v_r && st_r.frame_end;

  // Hold the summary in a register when a character goes in the same cycle; the held summary is written first.
  logic      pend_r;
  out_item_t pend_d_r;
  always_comb begin
    wr_en = 1'b0; wr_data = wa;
    if (pend_r) begin wr_en = 1'b1; wr_data = pend_d_r; end
    else if (wr_a) begin wr_en = 1'b1; wr_data = wa; end
    else if (wr_b) begin wr_en = 1'b1; wr_data = wb; end
  end

  always_ff @(posedge clk) begin
    if (wr_a && wr_b) pend_d_r <= wb;
    if (!rst_n) pend_r <= 1'b0;
    else pend_r <= wr_a && wr_b;
  end

  // Take a new request only if the queue still has room for its two results after
  // the writes already owed by the staged request and the held summary.
  // Hold off while the staged request needs both queue writes.
  assign in_ready = rst_n && !(wr_a && wr_b) &&
                    ({1'b0, fifo_cnt} + {3'd0, wr_a} + {3'd0, wr_b} + {3'd0, pend_r})
                    <= 4'd2;

  // advance frame state
  always_ff @(posedge clk) begin
    if (!rst_n || wr_b) begin
      cnt_r <= '0; eth_r <= '0; ihl_r <= '0; proto_r <= '0;
      src_hi_r <= '0; src_lo_r <= '0; dst_hi_r <= '0; dst_lo_r <= '0;
      ports_r <= '0; rcode_r <= '0; qd_r <= '0; left_r <= '0;
      nlen_r <= '0; labels_r <= '0; phase_r <= PH_IDLE;
    end else if (st_v_r) begin
      cnt_r <= len[COUNT_BITS-1:0];
      eth_r <= eth_n; ihl_r <= ihl_n; proto_r <= proto_n;
      src_hi_r <= shi_n; src_lo_r <= slo_n; dst_hi_r <= dhi_n; dst_lo_r <= dlo_n;
      ports_r <= ports_n; rcode_r <= rc_n; qd_r <= qd_n; left_r <= left_n;
      nlen_r <= nlen_n; labels_r <= lab_n; phase_r <= ph_n;
    end
  end

  eiudp_out_fifo u_fifo (
    .clk, .rst_n, .wr_en, .wr_data, .count(fifo_cnt),
    .out_valid, .out_ready, .out_data
  );
endmodule

// ----- tb/tb_ethernet_ip_udp_dns_header_parser_top.sv -----
// Testbench for the byte-serial header parser: random frames checked against a local predictor.
module tb_ethernet_ip_udp_dns_header_parser_top;
  import eiudp_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  ethernet_ip_udp_dns_header_parser_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Byte requests waiting for the driver, and parser results still owed by the block.
  in_item_t  byte_queue[$];
  out_item_t owed_results[$];
  logic [7:0] frame_buf[$];

  int idle_pct = 19;
  int err_count = 0;
  int frame_count = 0;
  int byte_count_sent = 0;
  int result_count = 0;
  logic in_took = 1'b0;

  // Predictor copy of the parser state and the DNS port register.
  logic [15:0] dns_port_cfg = DNS_PORT_RESET;
  logic [15:0] pos_count = '0;
  logic [15:0] ether_code = '0;
  logic [5:0]  ihl_bytes = '0;
  logic [7:0]  l4_proto = '0;
  logic [63:0] src_hi = '0, src_lo = '0, dst_hi = '0, dst_lo = '0;
  logic [31:0] ports = '0;
  logic [3:0]  rcode = '0;
  logic [15:0] qdcount = '0;
  logic [5:0]  label_rem = '0;
  logic [7:0]  chars_out = '0;
  logic [7:0]  labels_done = '0;
  logic [1:0]  name_ph = PH_IDLE;

  function automatic bit dns_char_ok(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == "-" || c == "_" || c == ".";
  endfunction

  function automatic bit port_hit();
    return ports[31:16] == dns_port_cfg || ports[15:0] == dns_port_cfg;
  endfunction

  function automatic int l4_offset();
    if (ether_code == ETH_IPV4 && ihl_bytes >= 20) return 14 + ihl_bytes;
    if (ether_code == ETH_IPV6) return 54;
    return 0;
  endfunction

  // Append one byte to the frame under construction.
  task automatic put_byte(logic [7:0] v);
    frame_buf = {frame_buf, v};
  endtask

  task automatic owe_char(logic [7:0] c);
    out_item_t r;
    r = '0;
    r.kind = KIND_CHAR;
    r.name_char = c;
    owed_results = {owed_results, r};
  endtask

  task automatic owe_summary();
    out_item_t r;
    int len, t;
    r = '0;
    len = int'(pos_count);
    t = 0;
    r.kind = KIND_SUM;
    if (len >= 14) begin
      if (ether_code == ETH_IPV4) begin
        if (len >= 34 && ihl_bytes >= 20 && len >= 14 + ihl_bytes) begin
          r.addr_kind = 2'd1;
          if (l4_proto == PROTO_TCP || l4_proto == PROTO_UDP) begin
            r.transport = (l4_proto == PROTO_TCP) ? 2'd1 : 2'd2;
            t = 14 + ihl_bytes;
          end
        end
      end else if (ether_code == ETH_IPV6) begin
        if (len >= 54 && (l4_proto == PROTO_TCP || l4_proto == PROTO_UDP)) begin
          r.addr_kind = 2'd2;
          r.transport = (l4_proto == PROTO_TCP) ? 2'd1 : 2'd2;
          t = 54;
        end
      end
    end
    if (r.transport == 2'd1 && len < t + 20) r.transport = 2'd0;
    if (r.transport == 2'd2 && len < t + 8) r.transport = 2'd0;
    if (r.transport == 2'd2 && port_hit() && len >= t + 20) begin
      r.dns_rcode = rcode;
      if (qdcount == 0) r.dns_state = 2'd1;
      else r.dns_state = (name_ph == PH_ACCEPT) ? 2'd2 : 2'd3;
    end
    if (r.addr_kind != 0) begin
      r.src_addr_hi = src_hi; r.src_addr_lo = src_lo;
      r.dst_addr_hi = dst_hi; r.dst_addr_lo = dst_lo;
    end
    if (r.transport != 0) begin
      r.src_port_out = ports[31:16];
      r.dst_port_out = ports[15:0];
    end
    owed_results = {owed_results, r};
  endtask

  // Advance the predictor by one accepted byte and queue the results it owes.
  task automatic parse_byte(in_item_t it);
    logic [7:0] b;
    int idx, t, k;
    b = it.frame_byte;
    idx = int'(pos_count);
    if (idx == 12) ether_code = {b, 8'h00};
    else if (idx == 13) ether_code[7:0] = b;
    else if (idx >= 14) begin
      if (ether_code == ETH_IPV4) begin
        if (idx == 14) ihl_bytes = {b[3:0], 2'b00};
        else if (idx == 23) l4_proto = b;
        else if (idx >= 26 && idx <= 29) src_lo = {src_lo[55:0], b};
        else if (idx >= 30 && idx <= 33) dst_lo = {dst_lo[55:0], b};
      end else if (ether_code == ETH_IPV6) begin
        if (idx == 20) l4_proto = b;
        else if (idx >= 22 && idx <= 29) src_hi = {src_hi[55:0], b};
        else if (idx >= 30 && idx <= 37) src_lo = {src_lo[55:0], b};
        else if (idx >= 38 && idx <= 45) dst_hi = {dst_hi[55:0], b};
        else if (idx >= 46 && idx <= 53) dst_lo = {dst_lo[55:0], b};
      end
      t = l4_offset();
      if (t != 0 && idx >= t) begin
        k = idx - t;
        if (k <= 3) ports = {ports[23:0], b};
        else if (k == 11) rcode = b[3:0];
        else if (k == 12 || k == 13) qdcount = {qdcount[7:0], b};
        else if (k == 20 && name_ph == PH_IDLE && l4_proto == PROTO_UDP && port_hit() &&
                 qdcount != 0)
          name_ph = PH_PARSE;
      end
    end

    // Walk the question name: length bytes open labels, other bytes are characters.
    if (name_ph == PH_PARSE) begin
      if (label_rem == 0) begin
        if (labels_done >= LABEL_LIMIT) name_ph = PH_REJECT;
        else if (b == 0) name_ph = PH_ACCEPT;
        else if (b[7:6] != 2'b00) name_ph = PH_REJECT;
        else if (labels_done > 0 && chars_out + 1 >= NAME_LIMIT) name_ph = PH_REJECT;
        else begin
          if (labels_done > 0) begin
            owe_char(".");
            chars_out++;
          end
          label_rem = b[5:0];
        end
      end else if (!dns_char_ok(b) || chars_out + 1 >= NAME_LIMIT) begin
        name_ph = PH_REJECT;
      end else begin
        owe_char(b);
        chars_out++;
        label_rem--;
        if (label_rem == 0) labels_done++;
      end
    end

    if (pos_count != 16'hFFFF) pos_count++;

    if (it.frame_end) begin
      owe_summary();
      pos_count = '0; ether_code = '0; ihl_bytes = '0; l4_proto = '0;
      src_hi = '0; src_lo = '0; dst_hi = '0; dst_lo = '0;
      ports = '0; rcode = '0; qdcount = '0; label_rem = '0;
      chars_out = '0; labels_done = '0; name_ph = PH_IDLE;
    end
  endtask

  task automatic check_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", fname, exp_v, act_v);
      err_count++;
    end
  endtask

  // Monitor: record accepted bytes and compare each accepted result with the oldest one owed.
  always @(posedge clk) begin
    out_item_t exp_r;
    in_took <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) parse_byte(in_data);
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (owed_results.size() == 0) begin
        $error("result with nothing owed: kind %0d char %0h", out_data.kind, out_data.name_char);
        err_count++;
      end else begin
        exp_r = owed_results.pop_front();
        check_field("kind", 64'(exp_r.kind), 64'(out_data.kind));
        check_field("name_char", 64'(exp_r.name_char), 64'(out_data.name_char));
        check_field("transport", 64'(exp_r.transport), 64'(out_data.transport));
        check_field("addr_kind", 64'(exp_r.addr_kind), 64'(out_data.addr_kind));
        check_field("src_addr_hi", exp_r.src_addr_hi, out_data.src_addr_hi);
        check_field("src_addr_lo", exp_r.src_addr_lo, out_data.src_addr_lo);
        check_field("dst_addr_hi", exp_r.dst_addr_hi, out_data.dst_addr_hi);
        check_field("dst_addr_lo", exp_r.dst_addr_lo, out_data.dst_addr_lo);
        check_field("src_port_out", 64'(exp_r.src_port_out), 64'(out_data.src_port_out));
        check_field("dst_port_out", 64'(exp_r.dst_port_out), 64'(out_data.dst_port_out));
        check_field("dns_state", 64'(exp_r.dns_state), 64'(out_data.dns_state));
        check_field("dns_rcode", 64'(exp_r.dns_rcode), 64'(out_data.dns_rcode));
      end
    end
  end

  // Driver: hold a request until it is taken, then advance to the next or idle.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold the current request
    end else if (byte_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
      in_data  <= byte_queue.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Stall the result channel at the same rate.
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= idle_pct);
  end

  task automatic add_rand(int n);
    repeat (n) put_byte(8'($urandom));
  endtask

  // Push the built frame as byte requests, flagging the last one.
  task automatic send_frame();
    in_item_t it;
    foreach (frame_buf[i]) begin
      it.frame_byte = frame_buf[i];
      it.frame_end  = (i == frame_buf.size() - 1);
      byte_queue = {byte_queue, it};
    end
    byte_count_sent += frame_buf.size();
    frame_count++;
    frame_buf.delete();
  endtask

  task automatic add_label(int len);
    logic [7:0] c;
    put_byte(8'(len));
    repeat (len) begin
      do c = 8'($urandom); while (!dns_char_ok(c));
      put_byte(c);
    end
  endtask

  // Build a question name: well formed most of the time, otherwise broken in one way.
  task automatic add_name();
    int mode;
    logic [7:0] c;
    mode = $urandom_range(99);
    if (mode < 50) begin
      repeat ($urandom_range(1, 4)) add_label(($urandom_range(9) == 0) ? 63 : $urandom_range(1, 8));
      put_byte(8'h00);
    end else if (mode < 58) begin
      // drop in a character outside the allowed set
      add_label($urandom_range(1, 5));
      put_byte(8'd4);
      do c = 8'($urandom); while (dns_char_ok(c));
      put_byte(c);
      add_rand(3);
    end else if (mode < 66) begin
      // compression pointer or label over 63
      add_label($urandom_range(1, 5));
      put_byte(8'($urandom_range(64, 255)));
      add_rand(2);
    end else if (mode < 74) begin
      // truncate mid name, or leave the name empty
      if ($urandom_range(1)) add_label($urandom_range(1, 6));
    end else if (mode < 80) begin
      repeat (5) add_label(63);
      put_byte(8'h00);
    end else if (mode < 85) begin
      repeat (130) add_label(1);
      put_byte(8'h00);
    end else begin
      put_byte(8'h00);
    end
  endtask

  // Build an Ethernet/IP/transport frame; DNS ports use the current register value.
  task automatic build_ip_frame(bit v6, logic [7:0] proto, int ihl_words, bit dns);
    logic [15:0] other;
    add_rand(12);
    if (v6) begin
      put_byte(ETH_IPV6[15:8]); put_byte(ETH_IPV6[7:0]);
      put_byte(8'h60);
      add_rand(5);
      put_byte(proto);
      add_rand(33);
    end else begin
      put_byte(ETH_IPV4[15:8]); put_byte(ETH_IPV4[7:0]);
      put_byte({4'($urandom_range(15)), ihl_words[3:0]});
      add_rand(8);
      put_byte(proto);
      add_rand(10);
      if (ihl_words > 5) add_rand(ihl_words * 4 - 20);
    end
    other = 16'($urandom);
    if (dns && $urandom_range(1)) begin
      put_byte(dns_port_cfg[15:8]); put_byte(dns_port_cfg[7:0]);
      put_byte(other[15:8]); put_byte(other[7:0]);
    end else if (dns) begin
      put_byte(other[15:8]); put_byte(other[7:0]);
      put_byte(dns_port_cfg[15:8]); put_byte(dns_port_cfg[7:0]);
    end else begin
      add_rand(4);
    end
    if (proto == PROTO_UDP) begin
      add_rand(4 + 4);
      if ($urandom_range(5) == 0) begin
        put_byte(8'h00); put_byte(8'h00);
      end else begin
        put_byte(8'($urandom)); put_byte(8'($urandom_range(1, 255)));
      end
      add_rand(6);
      add_name();
    end else begin
      add_rand(16);
    end
    add_rand($urandom_range(0, 6));
    // cut some frames short anywhere
    if ($urandom_range(9) == 0) begin
      int keep;
      keep = $urandom_range(1, frame_buf.size());
      while (frame_buf.size() > keep) void'(frame_buf.pop_back());
    end
  endtask

  task automatic random_frame();
    int r;
    r = $urandom_range(99);
    if (r < 50)
      build_ip_frame(1'b0, PROTO_UDP,
                     ($urandom_range(3) == 0) ? $urandom_range(5, 15) : 5, 1'b1);
    else if (r < 65) build_ip_frame(1'b1, PROTO_UDP, 5, 1'b1);
    else if (r < 75)
      build_ip_frame(1'($urandom_range(1)), PROTO_TCP, $urandom_range(5, 7), 1'b0);
    else if (r < 83)
      build_ip_frame(1'($urandom_range(1)), $urandom_range(1) ? PROTO_UDP : 8'($urandom),
                     5, 1'b0);
    else if (r < 90) build_ip_frame(1'b0, PROTO_UDP, $urandom_range(0, 4), 1'b1);
    else add_rand($urandom_range(1, 40));
    if (frame_buf.size() == 0) add_rand(1);
    send_frame();
  endtask

  // Write the DNS port register; only called with the block idle.
  task automatic write_dns_port(logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    dns_port_cfg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every request is taken and every owed result has come, then let the pipe drain.
  task automatic drain();
    do @(posedge clk); while (byte_queue.size() > 0 || in_valid || owed_results.size() > 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [15:0] port_set[4];
    int phase_bytes;
    port_set[0] = DNS_PORT_RESET;
    port_set[1] = 16'h0000;
    port_set[2] = 16'hFFFF;
    port_set[3] = 16'($urandom);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: one-byte frames at the byte extremes, a two-byte frame and a frame one byte short of a header.
    put_byte(8'h00); send_frame();
    put_byte(8'hFF); send_frame();
    put_byte(8'hAA); put_byte(8'h55); send_frame();
    add_rand(13); send_frame();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_dns_port(port_set[ph]);
      idle_pct = (ph == 2) ? 0 : 19;
      phase_bytes = byte_count_sent;
      while (byte_count_sent - phase_bytes < 80) random_frame();
      drain();
    end

    $display("Covered %0d frames, %0d bytes, %0d results over four DNS port settings.",
             frame_count, byte_count_sent, result_count);
    if (err_count == 0 && owed_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #8000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
